FILE: rtl/dpt_pkg.sv
// Shared types, constants and stage functions for the dewpoint pipeline.
// Used by dpt_tail and dewpoint_from_temp_and_humidity_top; no dependencies.
package dpt_pkg;

    localparam int RH_FRAC_BITS = 16;
    localparam int TEMP_W       = 16;
    localparam int RH_W         = 18;
    localparam int TD_W         = 16;
    localparam int S_TDATA_W    = 40;

    localparam logic [RH_W-1:0]   RH_MIN       = RH_W'((2**RH_FRAC_BITS + 9999) / 10000);
    localparam logic [16:0]       TEMP_DEN_OFS = 17'd2965;
    localparam logic signed [16:0] TEMP_C_OFS  = 17'sd27315;
    localparam logic signed [28:0] MAG_A_K     = 29'sd1767;
    localparam logic [22:0]       DEN_SCALE    = 23'd100;

    localparam int DA_QBITS  = 52;
    localparam int LOG_STEPS = 24;
    localparam int DB_QBITS  = 16;

    localparam logic [LOG_STEPS-1:0] FRAC_ONE  = LOG_STEPS'(1);
    localparam logic signed [29:0]  LOG2_OFS   = 30'(RH_FRAC_BITS * (2**LOG_STEPS));
    localparam logic signed [52:0]  DA_BIAS    = 53'(1) << (DA_QBITS - 1);
    localparam logic signed [32:0]  LN2_Q32    = 33'sd2977044472;
    localparam logic signed [62:0]  RND24      = 63'sd8388608;
    localparam logic signed [53:0]  RND16      = 54'sd32768;
    localparam logic signed [44:0]  MAG_B_Q16  = 45'sd115802112;
    localparam logic signed [44:0]  MAG_B_SCL  = 45'sd100;
    localparam logic [39:0]         NUM_C_U    = 40'd2435000;
    localparam logic signed [41:0]  NUM_C_S    = 42'sd2435000;

    localparam logic [TD_W-1:0] TD_MAX  = 16'd40000;
    localparam logic [TD_W-1:0] TD_ZERO = 16'd0;
    localparam logic [TD_W-1:0] Q_LO    = 16'd5453;
    localparam logic [TD_W-1:0] Q_HI    = 16'd45453;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_MISSING = 2'd1,
        ST_RANGE   = 2'd2
    } dpt_status_t;

    typedef struct packed {
        logic               miss;
        logic               tlo;
        logic signed [28:0] prod;
        logic [23:0]        dd;
        logic [4:0]         p;
        logic [30:0]        x;
    } dpt_front_t;

    typedef struct packed {
        logic                 miss;
        logic                 tlo;
        logic [23:0]          dd;
        logic [23:0]          rem;
        logic [DA_QBITS-1:0]  nq;
        logic [4:0]           p;
        logic [30:0]          x;
        logic [LOG_STEPS-1:0] frac;
    } dpt_da_t;

    typedef struct packed {
        logic                 miss;
        logic                 tlo;
        logic [DA_QBITS-1:0]  qa;
        logic [4:0]           p;
        logic [LOG_STEPS-1:0] frac;
    } dpt_mid_t;

    typedef struct packed {
        logic miss;
        logic tlo;
        logic dsat;
    } dpt_flg_t;

    typedef struct packed {
        dpt_flg_t             flg;
        logic                 ovf;
        logic [42:0]          dd2;
        logic [42:0]          rem;
        logic [DB_QBITS-1:0]  nq;
    } dpt_db_t;

    typedef struct packed {
        logic [TD_W-1:0] td;
        dpt_status_t     status;
    } dpt_res_t;

    function automatic dpt_da_t da_step(dpt_da_t s, int k);
        dpt_da_t     o;
        logic [24:0] rem2;
        logic [61:0] sq;
        logic [31:0] sh;
        o = s;
        rem2 = {s.rem, s.nq[DA_QBITS-1]};
        if (rem2 >= {1'b0, s.dd}) begin
            o.rem = 24'(rem2 - {1'b0, s.dd});
            o.nq  = {s.nq[DA_QBITS-2:0], 1'b1};
        end else begin
            o.rem = rem2[23:0];
            o.nq  = {s.nq[DA_QBITS-2:0], 1'b0};
        end
        if (k < LOG_STEPS) begin
            sq = 62'(s.x) * 62'(s.x);
            sh = sq[61:30];
            if (sh[31]) begin
                o.x    = sh[31:1];
                o.frac = s.frac | (FRAC_ONE << (LOG_STEPS - 1 - k));
            end else begin
                o.x = sh[30:0];
            end
        end
        return o;
    endfunction

    function automatic dpt_db_t db_step(dpt_db_t s);
        dpt_db_t     o;
        logic [43:0] rem2;
        o = s;
        rem2 = {s.rem, s.nq[DB_QBITS-1]};
        if (rem2 >= {1'b0, s.dd2}) begin
            o.rem = 43'(rem2 - {1'b0, s.dd2});
            o.nq  = {s.nq[DB_QBITS-2:0], 1'b1};
        end else begin
            o.rem = rem2[42:0];
            o.nq  = {s.nq[DB_QBITS-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

FILE: rtl/dewpoint_from_temp_and_humidity_top.sv
// Dewpoint from temperature and humidity, Magnus form, fully pipelined.
// Throughput: one transfer per cycle while not stalled by the output skid register;
// latency is set mostly by the 52-stage divider for a.
// s_axis_tready drops only while the output skid register holds a result.
// aresetn (synchronous) clears all valid bits; payload registers are not reset.
// Depends on dpt_pkg and dpt_tail.
module dewpoint_from_temp_and_humidity_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [dpt_pkg::S_TDATA_W-1:0] s_axis_tdata,  // temp_centik, rh_q16, zero pad
    input  logic                          s_axis_tuser,  // rh_absent
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [dpt_pkg::TD_W-1:0]      m_axis_tdata,  // dewpoint_centik
    output logic [1:0]                    m_axis_tuser   // status
);

    logic en;

    logic [dpt_pkg::TEMP_W-1:0] temp;
    logic [dpt_pkg::RH_W-1:0]   rh;
    logic signed [16:0]         den;
    logic signed [16:0]         tcc;

    dpt_pkg::dpt_front_t fr_reg, fr_next;
    logic                fr_vld_reg;

    dpt_pkg::dpt_da_t dv_reg  [0:dpt_pkg::DA_QBITS];
    dpt_pkg::dpt_da_t dv_next [0:dpt_pkg::DA_QBITS];
    logic [dpt_pkg::DA_QBITS:0] dv_vld_reg;
    logic [42:0]                hi;

    dpt_pkg::dpt_mid_t mid;
    dpt_pkg::dpt_res_t tail_res;
    logic              tail_vld;
    logic              take;

    dpt_pkg::dpt_res_t out_reg, out_next, skid_reg, skid_next;
    logic              out_vld_reg, out_vld_next, skid_vld_reg, skid_vld_next;

    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;

    always_comb begin
        temp = s_axis_tdata[15:0];
        rh   = s_axis_tdata[33:16];
        den  = signed'({1'b0, temp}) - signed'(dpt_pkg::TEMP_DEN_OFS);
        tcc  = signed'({1'b0, temp}) - dpt_pkg::TEMP_C_OFS;
        fr_next.miss = s_axis_tuser || (rh < dpt_pkg::RH_MIN);
        fr_next.tlo  = den[16] || (den == '0);
        fr_next.prod = 29'(tcc) * dpt_pkg::MAG_A_K;
        fr_next.dd   = {23'(den[15:0]) * dpt_pkg::DEN_SCALE, 1'b0};
        fr_next.p    = '0;
        for (int i = 0; i < dpt_pkg::RH_W; i++) begin
            if (rh[i]) begin
                fr_next.p = 5'(i);
            end
        end
        fr_next.x = 31'(rh) << (5'd30 - fr_next.p);
    end

    always_comb begin
        hi = (43'(fr_reg.dd) << 18) + 43'(fr_reg.prod);
        dv_next[0].miss = fr_reg.miss;
        dv_next[0].tlo  = fr_reg.tlo;
        dv_next[0].dd   = fr_reg.dd;
        dv_next[0].rem  = hi[42:19];
        dv_next[0].nq   = {hi[18:0], 10'b0, fr_reg.dd[23:1]};
        dv_next[0].p    = fr_reg.p;
        dv_next[0].x    = fr_reg.x;
        dv_next[0].frac = '0;
        for (int k = 0; k < dpt_pkg::DA_QBITS; k++) begin
            dv_next[k+1] = dpt_pkg::da_step(dv_reg[k], k);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_vld_reg <= 1'b0;
            dv_vld_reg <= '0;
        end else if (en) begin
            fr_vld_reg <= s_axis_tvalid;
            dv_vld_reg <= {dv_vld_reg[dpt_pkg::DA_QBITS-1:0], fr_vld_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fr_reg <= fr_next;
            dv_reg <= dv_next;
        end
    end

    assign mid.miss = dv_reg[dpt_pkg::DA_QBITS].miss;
    assign mid.tlo  = dv_reg[dpt_pkg::DA_QBITS].tlo;
    assign mid.qa   = dv_reg[dpt_pkg::DA_QBITS].nq;
    assign mid.p    = dv_reg[dpt_pkg::DA_QBITS].p;
    assign mid.frac = dv_reg[dpt_pkg::DA_QBITS].frac;

    dpt_tail u_tail (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (dv_vld_reg[dpt_pkg::DA_QBITS]),
        .mid     (mid),
        .out_vld (tail_vld),
        .res     (tail_res)
    );

    assign take = tail_vld && en;

    always_comb begin
        out_next      = out_reg;
        out_vld_next  = out_vld_reg;
        skid_next     = skid_reg;
        skid_vld_next = skid_vld_reg;
        if (!out_vld_reg || m_axis_tready) begin
            if (skid_vld_reg) begin
                out_next      = skid_reg;
                out_vld_next  = 1'b1;
                skid_vld_next = 1'b0;
            end else begin
                out_next     = tail_res;
                out_vld_next = take;
            end
        end else if (take) begin
            skid_next     = tail_res;
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg.td;
    assign m_axis_tuser  = out_reg.status;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_axis_tvalid)
        else $error("skid holds a result while the output register is empty");

    a_missing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == dpt_pkg::ST_MISSING) |-> m_axis_tdata == '0)
        else $error("missing status with nonzero dewpoint");

    a_td_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata <= dpt_pkg::TD_MAX)
        else $error("dewpoint above saturation limit");

    a_valid_in_band: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == dpt_pkg::ST_VALID) |-> m_axis_tdata != '0)
        else $error("valid status with zero dewpoint");

endmodule

FILE: rtl/dpt_tail.sv
// Back end of the dewpoint pipeline: ln scaling, fact, final divide, saturation.
// Depends on dpt_pkg; advances only while en is high.
module dpt_tail (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  dpt_pkg::dpt_mid_t mid,
    output logic              out_vld,
    output dpt_pkg::dpt_res_t res
);

    localparam int DEPTH = 8 + dpt_pkg::DB_QBITS + 2;

    logic [DEPTH-1:0] vld_reg;

    dpt_pkg::dpt_flg_t  fl_reg [0:7];
    dpt_pkg::dpt_flg_t  fl_next [0:7];

    logic signed [29:0] l_reg, l_next;
    logic signed [52:0] a1_reg, a1_next, a2_reg, a3_reg;
    logic signed [62:0] m_reg, m_next, mr;
    logic signed [38:0] ln_reg, ln_next;
    logic signed [53:0] fact_reg, fact_next, fr;
    logic signed [37:0] f_reg, f_next;
    logic signed [44:0] d_reg, d_next;
    logic [39:0]        pl_reg, pl_next;
    logic signed [41:0] ph_reg, ph_next;
    logic [59:0]        n_reg, n_next;
    logic [42:0]        dd2a_reg, dd2a_next, dd2b_reg;
    logic [59:0]        tp_reg, tp_next;

    dpt_pkg::dpt_db_t db_reg  [0:dpt_pkg::DB_QBITS];
    dpt_pkg::dpt_db_t db_next [0:dpt_pkg::DB_QBITS];
    dpt_pkg::dpt_res_t res_reg, res_next;

    always_comb begin
        fl_next[0]      = '{miss: mid.miss, tlo: mid.tlo, dsat: 1'b0};
        l_next          = signed'(30'({mid.p, mid.frac})) - dpt_pkg::LOG2_OFS;
        a1_next         = signed'(53'(mid.qa)) - dpt_pkg::DA_BIAS;
        fl_next[1]      = fl_reg[0];
        m_next          = 63'(l_reg) * 63'(dpt_pkg::LN2_Q32);
        fl_next[2]      = fl_reg[1];
        mr              = m_reg + dpt_pkg::RND24;
        ln_next         = mr[62:24];
        fl_next[3]      = fl_reg[2];
        fact_next       = 54'(ln_reg) + 54'(a3_reg);
        fl_next[4]      = fl_reg[3];
        fr              = fact_reg + dpt_pkg::RND16;
        f_next          = fr[53:16];
        fl_next[5]      = fl_reg[4];
        d_next          = dpt_pkg::MAG_B_Q16 - 45'(f_reg) * dpt_pkg::MAG_B_SCL;
        pl_next         = 40'(f_reg[17:0]) * dpt_pkg::NUM_C_U;
        ph_next         = 42'(signed'(f_reg[37:18])) * dpt_pkg::NUM_C_S;
        fl_next[6]      = fl_reg[5];
        fl_next[6].dsat = d_reg[44] || (d_reg == '0);
        n_next          = (60'(ph_reg) << 18) + 60'(pl_reg);
        dd2a_next       = {d_reg[41:0], 1'b0};
        fl_next[7]      = fl_reg[6];
        tp_next         = {n_reg[58:0], 1'b0} + 60'(dd2a_reg[42:1])
                          + 60'({dd2a_reg, 15'b0});

        db_next[0].flg = fl_reg[7];
        db_next[0].ovf = tp_reg[59:16] >= {1'b0, dd2b_reg};
        db_next[0].dd2 = dd2b_reg;
        db_next[0].rem = tp_reg[58:16];
        db_next[0].nq  = tp_reg[15:0];
        for (int k = 0; k < dpt_pkg::DB_QBITS; k++) begin
            db_next[k+1] = dpt_pkg::db_step(db_reg[k]);
        end
    end

    always_comb begin
        dpt_pkg::dpt_db_t s;
        s = db_reg[dpt_pkg::DB_QBITS];
        res_next.td     = dpt_pkg::TD_ZERO;
        res_next.status = dpt_pkg::ST_RANGE;
        if (s.flg.miss) begin
            res_next.status = dpt_pkg::ST_MISSING;
        end else if (s.flg.tlo) begin
            res_next.td = dpt_pkg::TD_ZERO;
        end else if (s.flg.dsat || s.ovf || s.nq > dpt_pkg::Q_HI) begin
            res_next.td = dpt_pkg::TD_MAX;
        end else if (s.nq < dpt_pkg::Q_LO) begin
            res_next.td = dpt_pkg::TD_ZERO;
        end else begin
            res_next.td     = s.nq - dpt_pkg::Q_LO;
            res_next.status = dpt_pkg::ST_VALID;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fl_reg   <= fl_next;
            l_reg    <= l_next;
            a1_reg   <= a1_next;
            a2_reg   <= a1_reg;
            a3_reg   <= a2_reg;
            m_reg    <= m_next;
            ln_reg   <= ln_next;
            fact_reg <= fact_next;
            f_reg    <= f_next;
            d_reg    <= d_next;
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            n_reg    <= n_next;
            dd2a_reg <= dd2a_next;
            dd2b_reg <= dd2a_reg;
            tp_reg   <= tp_next;
            db_reg   <= db_next;
            res_reg  <= res_next;
        end
    end

    assign out_vld = vld_reg[DEPTH-1];
    assign res     = res_reg;

endmodule

FILE: bench/dewpoint_from_temp_and_humidity_top_tb.sv
// Testbench for dewpoint_from_temp_and_humidity_top: directed table plus random samples,
// checked against an integer Magnus dewpoint predictor. Depends on dpt_pkg and the RTL.
module dewpoint_from_temp_and_humidity_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1700;
    localparam int WATCHDOG = 5000;
    localparam int LATENCY  = 80;

    typedef struct {
        logic [15:0]          temp;
        logic [17:0]          rh;
        logic                 absent;
        logic                 known;
        logic [15:0]          td;
        dpt_pkg::dpt_status_t st;
    } dir_row_t;

    typedef struct {
        logic [15:0]          td;
        dpt_pkg::dpt_status_t st;
    } dew_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [dpt_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;  // temp_centik, rh_q16, zero pad
    logic s_axis_tuser = 1'b0;                          // rh_absent
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [dpt_pkg::TD_W-1:0] m_axis_tdata;             // dewpoint_centik
    logic [1:0] m_axis_tuser;                           // status

    dew_t dew_q[$];
    int errors = 0;
    int sent = 0;
    int got = 0;
    int idle_cycles = 0;
    bit done_send = 0;
    dir_row_t rows[$];

    dewpoint_from_temp_and_humidity_top dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint round_div(longint n, longint d);
        longint t, dd, q;
        t = 2 * n + d;
        dd = 2 * d;
        q = t / dd;
        if ((t % dd) != 0 && t < 0) q--;
        return q;
    endfunction

    function automatic longint log2_q24(longint unsigned r);
        int p;
        longint unsigned x, frac;
        p = 0;
        frac = 0;
        while (p < 17 && (r >> (p + 1)) != 0) p++;
        x = r << (30 - p);
        for (int i = 0; i < 24; i++) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
                x >>= 1;
                frac |= 64'd1 << (23 - i);
            end
        end
        return longint'((longint'(p) << 24) | frac);
    endfunction

    function automatic dew_t dewpoint(logic [15:0] temp, logic [17:0] rh, logic absent);
        dew_t o;
        longint tcc, a, lnrh, fact, f, d, td;
        tcc = longint'(temp) - 27315;
        o.td = '0;
        o.st = dpt_pkg::ST_VALID;
        if (absent || longint'(rh) * 10000 < (64'd1 << dpt_pkg::RH_FRAC_BITS)) begin
            o.st = dpt_pkg::ST_MISSING;
            return o;
        end
        if (tcc + 24350 <= 0) begin
            o.st = dpt_pkg::ST_RANGE;
            return o;
        end
        a = round_div(1767 * tcc * 64'sd4294967296, 100 * (tcc + 24350));
        lnrh = round_div((log2_q24(rh) - longint'(dpt_pkg::RH_FRAC_BITS) * 16777216)
                         * 64'sd2977044472, 16777216);
        fact = lnrh + a;
        f = round_div(fact, 65536);
        d = 1767 * 65536 - 100 * f;
        if (d <= 0) begin
            o.td = 16'd40000;
            o.st = dpt_pkg::ST_RANGE;
            return o;
        end
        td = 27315 + round_div(2435000 * f, d);
        if (td < 0) begin
            td = 0;
            o.st = dpt_pkg::ST_RANGE;
        end else if (td > 40000) begin
            td = 40000;
            o.st = dpt_pkg::ST_RANGE;
        end
        o.td = td[15:0];
        return o;
    endfunction

    function automatic dir_row_t mk(int t, int r, bit ab, bit k, int td,
                                    dpt_pkg::dpt_status_t st);
        dir_row_t x;
        x.temp = t[15:0];
        x.rh = r[17:0];
        x.absent = ab;
        x.known = k;
        x.td = td[15:0];
        x.st = st;
        return x;
    endfunction

    task automatic send(logic [15:0] t, logic [17:0] r, logic ab);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, r, t};
        s_axis_tuser <= ab;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        dew_q.push_back(dewpoint(t, r, ab));
        sent++;
    endtask

    initial begin
        dir_row_t row;
        rows.push_back(mk(29315, 32768, 1, 1, 0, dpt_pkg::ST_MISSING));
        rows.push_back(mk(29315, 0, 0, 1, 0, dpt_pkg::ST_MISSING));
        rows.push_back(mk(29315, 6, 0, 1, 0, dpt_pkg::ST_MISSING));
        rows.push_back(mk(29315, 7, 0, 0, 0, dpt_pkg::ST_VALID));
        rows.push_back(mk(2964, 65536, 0, 1, 0, dpt_pkg::ST_RANGE));
        rows.push_back(mk(0, 65536, 0, 1, 0, dpt_pkg::ST_RANGE));
        rows.push_back(mk(2965, 65536, 0, 0, 0, dpt_pkg::ST_VALID));
        rows.push_back(mk(65535, 262143, 0, 1, 40000, dpt_pkg::ST_RANGE));
        rows.push_back(mk(65535, 65536, 0, 0, 0, dpt_pkg::ST_VALID));
        rows.push_back(mk(17315, 7, 0, 0, 0, dpt_pkg::ST_VALID));
        rows.push_back(mk(17315, 65536, 0, 0, 0, dpt_pkg::ST_VALID));
        rows.push_back(mk(37315, 65536, 0, 0, 0, dpt_pkg::ST_VALID));
        rows.push_back(mk(37315, 262143, 0, 0, 0, dpt_pkg::ST_VALID));
        rows.push_back(mk(27315, 65536, 0, 0, 0, dpt_pkg::ST_VALID));
        rows.push_back(mk(27315, 131072, 0, 0, 0, dpt_pkg::ST_VALID));
        rows.push_back(mk(30315, 16384, 0, 0, 0, dpt_pkg::ST_VALID));
        rows.push_back(mk(25315, 1000, 0, 0, 0, dpt_pkg::ST_VALID));
        rows.push_back(mk(17315, 262143, 1, 1, 0, dpt_pkg::ST_MISSING));
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (rows[i]) begin
            row = rows[i];
            send(row.temp, row.rh, row.absent);
            if (row.known) begin
                dew_q[$].td = row.td;
                dew_q[$].st = row.st;
            end
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            int sel;
            logic [15:0] t;
            logic [17:0] r;
            if (i == N_RANDOM / 2) begin
                s_axis_tvalid <= 1'b0;
                do @(posedge aclk); while (dew_q.size() != 0);
            end
            sel = $urandom_range(0, 19);
            t = 16'($urandom_range(17315, 37315));
            r = 18'($urandom_range(7, 78643));
            if (sel == 0) t = 16'($urandom);
            if (sel == 1) r = 18'($urandom);
            if (sel == 2) r = 18'($urandom_range(0, 10));
            send(t, r, sel == 3 ? 1'b1 : 1'($urandom_range(0, 19) == 0));
        end
        s_axis_tvalid <= 1'b0;
        done_send = 1;
    end

    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            dew_t e;
            got++;
            if (dew_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result td=%0d st=%0d", $time, m_axis_tdata,
                         m_axis_tuser);
            end else begin
                e = dew_q.pop_front();
                if (m_axis_tdata !== e.td || m_axis_tuser !== e.st) begin
                    errors++;
                    $display("%0t mismatch expected td=%0d st=%0d actual td=%0d st=%0d",
                             $time, e.td, e.st, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        @(posedge aclk iff ((done_send && dew_q.size() == 0) || idle_cycles >= WATCHDOG));
        if (idle_cycles >= WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
        end
        repeat (LATENCY + 20) @(posedge aclk);
        $display("Covered %0d samples and %0d dewpoints: missing, cold, saturated and normal.",
                 sent, got);
        if (errors == 0 && dew_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
